// ----- src/ffba_pkg.sv -----
// package: microcode types, control codes and program table of the block allocator
`default_nettype none
package ffba_pkg;

    // datapath actions
    localparam logic [3:0] ACT_NONE    = 4'd0;
    localparam logic [3:0] ACT_ACCEPT  = 4'd1;
    localparam logic [3:0] ACT_INIT    = 4'd2;
    localparam logic [3:0] ACT_READ    = 4'd3;
    localparam logic [3:0] ACT_ADVANCE = 4'd4;
    localparam logic [3:0] ACT_FAIL    = 4'd5;
    localparam logic [3:0] ACT_FREE    = 4'd6;
    localparam logic [3:0] ACT_ALLOC   = 4'd7;
    localparam logic [3:0] ACT_POST    = 4'd8;

    // branch conditions
    localparam logic [2:0] C_ALWAYS   = 3'd0;
    localparam logic [2:0] C_IN_FIRE  = 3'd1;
    localparam logic [2:0] C_IS_FREE  = 3'd2;
    localparam logic [2:0] C_BAD_SIZE = 3'd3;
    localparam logic [2:0] C_U_PAST   = 3'd4;
    localparam logic [2:0] C_FIT      = 3'd5;
    localparam logic [2:0] C_OUT_FULL = 3'd6;

    // program steps
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DISP   = 4'd1;
    localparam logic [3:0] ST_CHK    = 4'd2;
    localparam logic [3:0] ST_ISSUE  = 4'd3;
    localparam logic [3:0] ST_EVAL   = 4'd4;
    localparam logic [3:0] ST_FAIL   = 4'd5;
    localparam logic [3:0] ST_FREE   = 4'd6;
    localparam logic [3:0] ST_COMMIT = 4'd7;
    localparam logic [3:0] ST_POST   = 4'd8;

    // largest request whose length header still fits in a byte
    localparam logic [7:0] MAX_REQ = 8'd254;

    typedef struct packed {
        logic [3:0] act;
        logic [2:0] cond;
        logic [3:0] t_true;
        logic [3:0] t_false;
    } t_uword;

    typedef struct packed {
        logic [3:0] act;
    } t_ctrl;

    typedef struct packed {
        logic in_fire;
        logic is_free;
        logic bad_size;
        logic u_past;
        logic fit;
        logic out_full;
    } t_stat;

    function automatic t_uword micro_rom(input logic [3:0] pc);
        t_uword w;
        case (pc)
            ST_IDLE:   w = '{ACT_ACCEPT,  C_IN_FIRE,  ST_DISP,   ST_IDLE};
            ST_DISP:   w = '{ACT_INIT,    C_IS_FREE,  ST_FREE,   ST_CHK};
            ST_CHK:    w = '{ACT_NONE,    C_BAD_SIZE, ST_FAIL,   ST_ISSUE};
            ST_ISSUE:  w = '{ACT_READ,    C_U_PAST,   ST_FAIL,   ST_EVAL};
            ST_EVAL:   w = '{ACT_ADVANCE, C_FIT,      ST_COMMIT, ST_ISSUE};
            ST_FAIL:   w = '{ACT_FAIL,    C_ALWAYS,   ST_POST,   ST_POST};
            ST_FREE:   w = '{ACT_FREE,    C_ALWAYS,   ST_POST,   ST_POST};
            ST_COMMIT: w = '{ACT_ALLOC,   C_ALWAYS,   ST_POST,   ST_POST};
            ST_POST:   w = '{ACT_POST,    C_OUT_FULL, ST_POST,   ST_IDLE};
            default:   w = '{ACT_NONE,    C_ALWAYS,   ST_IDLE,   ST_IDLE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- src/first_fit_block_allocator_top.sv -----
// top level of the first-fit block allocator with length headers
//
//  channel  | direction | tdata                               | tuser
//  s_axis   | in        | [7:0] request_size, [15:8] handle_in | [0] mode (0 alloc, 1 free)
//  m_axis   | out       | [7:0] handle_out                     | [0] ok
//
// one item at a time; a free runs the dispatch, free and post steps from accept to result
// an allocate runs dispatch and size check, then the probes of the scan, one per unit probed
// (at most POOL_SIZE), then commit or fail and the post step; a scan off the pool end fails;
// each probe is one ram read and one evaluate step of the microcode loop
// after reset the pool is empty: per-unit valid bits clear while reset is held;
// no item is taken while reset is held
// a stalled result holds in the output register; the next item is taken while
// it waits, and the sequencer only waits if a second result is ready first
`default_nettype none
module first_fit_block_allocator_top
    import ffba_pkg::*;
#(
    parameter int POOL_SIZE = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] request_size, [15:8] handle_in
    input  wire logic        s_axis_tuser,   // [0] mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] handle_out
    output logic             m_axis_tuser    // [0] ok
);

    t_ctrl ctrl;
    t_stat stat;

    // program counter and control word
    ffba_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    // scan datapath, header store and output register
    ffba_dp #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .o_stat       (stat),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_mode    (s_axis_tuser),
        .i_in_size    (s_axis_tdata[7:0]),
        .i_in_handle  (s_axis_tdata[15:8]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_ok     (m_axis_tuser),
        .o_out_handle (m_axis_tdata)
    );

endmodule
`default_nettype wire

// ----- src/ffba_ram.sv -----
// generic single-write single-read ram with registered read data
`default_nettype none
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- src/ffba_useq.sv -----
// microcode sequencer: step counter, program table and conditional jumps
`default_nettype none
module ffba_useq
    import ffba_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_stat i_stat,
    output t_ctrl      o_ctrl
);

    logic [3:0] r_pc;
    logic [3:0] n_pc;
    t_uword     uw;
    logic       cond_hit;

    assign uw = micro_rom(r_pc);

    always_comb begin
        case (uw.cond)
            C_ALWAYS:   cond_hit = 1'b1;
            C_IN_FIRE:  cond_hit = i_stat.in_fire;
            C_IS_FREE:  cond_hit = i_stat.is_free;
            C_BAD_SIZE: cond_hit = i_stat.bad_size;
            C_U_PAST:   cond_hit = i_stat.u_past;
            C_FIT:      cond_hit = i_stat.fit;
            C_OUT_FULL: cond_hit = i_stat.out_full;
            default:    cond_hit = 1'b1;
        endcase
        n_pc = cond_hit ? uw.t_true : uw.t_false;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.act = uw.act;

endmodule
`default_nettype wire

// ----- src/ffba_dp.sv -----
// datapath: scan pointers, header store with valid bits, result and output registers
`default_nettype none
module ffba_dp
    import ffba_pkg::*;
#(
    parameter int POOL_SIZE = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_ctrl       i_ctrl,
    output t_stat            o_stat,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_in_mode,
    input  wire logic [7:0]  i_in_size,
    input  wire logic [7:0]  i_in_handle,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_out_ok,
    output logic [7:0]       o_out_handle
);

    localparam int AW = $clog2(POOL_SIZE);
    // scan pointer must hold a unit index plus one header value
    localparam int UW = $clog2(POOL_SIZE + 256);

    logic           r_mode;
    logic [7:0]     r_size;
    logic [7:0]     r_handle;
    logic [7:0]     r_total;
    logic [UW-1:0]  r_pos;
    logic [UW-1:0]  r_u;
    logic [7:0]     r_i;
    logic           r_rdv;
    logic [POOL_SIZE-1:0] r_vld;
    logic           r_res_ok;
    logic [7:0]     r_res_handle;
    logic           r_out_valid;
    logic           r_out_ok;
    logic [7:0]     r_out_handle;

    logic [7:0]     ram_q;
    logic [7:0]     hdr_v;
    logic [UW-1:0]  u_jump;
    logic [UW-1:0]  pos_p1;
    logic [7:0]     handle_m1;
    logic           free_hit;
    logic           u_past;
    logic           ram_re;
    logic           ram_we;

    assign hdr_v     = r_rdv ? ram_q : 8'd0;
    assign u_jump    = r_u + UW'(hdr_v);
    assign pos_p1    = r_pos + UW'(1);
    assign handle_m1 = r_handle - 8'd1;
    assign free_hit  = (r_handle != 8'd0) && ({1'b0, r_handle} <= 9'(POOL_SIZE));
    assign u_past    = r_u >= UW'(POOL_SIZE);
    assign ram_re    = (i_ctrl.act == ACT_READ) && !u_past;
    assign ram_we    = (i_ctrl.act == ACT_ALLOC);

    assign o_stat.in_fire  = i_in_valid;
    assign o_stat.is_free  = r_mode;
    assign o_stat.bad_size = (r_size == 8'd0) || (r_size > MAX_REQ);
    assign o_stat.u_past   = u_past;
    assign o_stat.fit      = (hdr_v == 8'd0) && (({1'b0, r_i} + 9'd1) == {1'b0, r_total});
    assign o_stat.out_full = r_out_valid;

    // no item is taken while reset is held
    assign o_in_ready   = (i_ctrl.act == ACT_ACCEPT) && i_rst_n;
    assign o_out_valid  = r_out_valid;
    assign o_out_ok     = r_out_ok;
    assign o_out_handle = r_out_handle;

    ffba_ram #(
        .WIDTH (8),
        .DEPTH (POOL_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos[AW-1:0]),
        .i_wdata (r_total),
        .i_re    (ram_re),
        .i_raddr (r_u[AW-1:0]),
        .o_rdata (ram_q)
    );

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        case (i_ctrl.act)
            ACT_ACCEPT: begin
                if (i_in_valid) begin
                    r_mode   <= i_in_mode;
                    r_size   <= i_in_size;
                    r_handle <= i_in_handle;
                end
            end
            ACT_INIT: begin
                r_pos   <= '0;
                r_u     <= '0;
                r_i     <= 8'd0;
                r_total <= r_size + 8'd1;
            end
            ACT_READ: begin
                r_rdv <= r_vld[r_u[AW-1:0]];
            end
            ACT_ADVANCE: begin
                if (hdr_v != 8'd0) begin
                    r_pos <= u_jump;
                    r_u   <= u_jump;
                    r_i   <= 8'd0;
                end else begin
                    r_u <= r_u + UW'(1);
                    r_i <= r_i + 8'd1;
                end
            end
            ACT_FAIL: begin
                r_res_ok     <= 1'b0;
                r_res_handle <= 8'd0;
            end
            ACT_FREE: begin
                r_res_ok     <= 1'b1;
                r_res_handle <= 8'd0;
            end
            ACT_ALLOC: begin
                r_res_ok     <= 1'b1;
                r_res_handle <= pos_p1[7:0];
            end
            ACT_POST: begin
                if (!r_out_valid) begin
                    r_out_ok     <= r_res_ok;
                    r_out_handle <= r_res_handle;
                end
            end
            default: begin
            end
        endcase
    end

    // valid bits and output flag; units covered by a block are always zero,
    // so freeing only has to drop the header
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ram_we) begin
                r_vld[r_pos[AW-1:0]] <= 1'b1;
            end
            if ((i_ctrl.act == ACT_FREE) && free_hit) begin
                r_vld[handle_m1[AW-1:0]] <= 1'b0;
            end
            if ((i_ctrl.act == ACT_POST) && !r_out_valid) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/ffba_chk.sv -----
// port-level checks of the block allocator and their bind to the top level
`default_nettype none
module ffba_chk #(
    parameter int POOL_SIZE = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata,
    input  wire logic        m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a nonzero handle only comes with success
    a_handle_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata != 8'd0) |-> m_axis_tuser)
        else $error("handle without ok");

    // a returned handle, the unit after a new block's header, lies inside the pool
    a_handle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ({1'b0, m_axis_tdata} < 9'(POOL_SIZE)))
        else $error("handle beyond pool");

    // one item at a time: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

endmodule

bind first_fit_block_allocator_top ffba_chk #(.POOL_SIZE(POOL_SIZE)) u_ffba_chk (.*);
`default_nettype wire
